// ----- src/msrm_pkg.sv -----
// Shared types and constants for the motor stall and runaway monitor.
package msrm_pkg;

   // Item kinds carried on the request tuser
   localparam logic [1:0] MODE_ENC_LEFT  = 2'd0;
   localparam logic [1:0] MODE_ENC_RIGHT = 2'd1;
   localparam logic [1:0] MODE_CURRENT   = 2'd2;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_LIMIT        = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISTANCE_LIMIT    = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_LIMIT     = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STALL_COUNT_LIMIT = 8'd3;

   // Register reset values
   localparam logic [15:0] RATE_LIMIT_RST        = 16'd1900;
   localparam logic [15:0] DISTANCE_LIMIT_RST    = 16'd156;
   localparam logic [14:0] CURRENT_LIMIT_RST     = 15'd1000;
   localparam logic [7:0]  STALL_COUNT_LIMIT_RST = 8'd5;

   localparam logic [9:0] MS_PER_SECOND = 10'd1000;
   localparam logic [7:0] RUN_MAX       = 8'hFF;

   typedef struct packed {
      logic [15:0] rate_limit;
      logic [15:0] distance_limit;
      logic [14:0] current_limit;
      logic [7:0]  stall_count_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] encoder_count;
      logic [31:0]        time_ms;
      logic signed [15:0] current_left;
      logic signed [15:0] current_right;
   } item_type;

   typedef struct packed {
      logic estop;
      logic runaway_trip;
      logic fault_motor;
      logic stall_left;
      logic stall_right;
   } res_type;

endpackage

// ----- src/msrm_csr.sv -----
// Configuration register bank for the motor stall and runaway monitor.
module msrm_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [msrm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [15:0]                          csr_data,
   output msrm_pkg::cfg_type                    cfg
);
   import msrm_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_RATE_LIMIT:        cfg_in.rate_limit = csr_data;
            CSR_DISTANCE_LIMIT:    cfg_in.distance_limit = csr_data;
            CSR_CURRENT_LIMIT:     cfg_in.current_limit = csr_data[14:0];
            CSR_STALL_COUNT_LIMIT: cfg_in.stall_count_limit = csr_data[7:0];
            default:               cfg_in = cfg_ff; // drop unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_limit        <= RATE_LIMIT_RST;
         cfg_ff.distance_limit    <= DISTANCE_LIMIT_RST;
         cfg_ff.current_limit     <= CURRENT_LIMIT_RST;
         cfg_ff.stall_count_limit <= STALL_COUNT_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/msrm_core.sv -----
// Per-motor state and the combinational stall and runaway evaluation.
module msrm_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  msrm_pkg::item_type item,
   input  msrm_pkg::cfg_type  cfg,
   output msrm_pkg::res_type  res
);
   import msrm_pkg::*;

   logic [1:0]  primed_ff, primed_in;
   logic [31:0] prev_count_ff [2];
   logic [31:0] prev_count_in [2];
   logic [31:0] prev_time_ff  [2];
   logic [31:0] prev_time_in  [2];
   logic [31:0] acc_ff        [2];
   logic [31:0] acc_in        [2];
   logic [7:0]  run_ff        [2];
   logic [7:0]  run_in        [2];

   logic        sel;
   logic [31:0] diff, mag, dt, acc_sat;
   logic [41:0] lhs;
   logic [47:0] rhs;
   logic [32:0] acc_sum;
   logic        fast, trip, fault;
   logic [15:0] mag_left, mag_right;
   logic        over_left, over_right;

   function automatic logic [15:0] cur_mag(input logic signed [15:0] v);
      logic [15:0] u;
      u = $unsigned(v);
      cur_mag = v[15] ? (16'd0 - u) : u;
   endfunction

   function automatic logic [7:0] run_next(input logic [7:0] run, input logic over);
      if (!over) begin
         run_next = 8'd0;
      end else if (run == RUN_MAX) begin
         run_next = RUN_MAX;
      end else begin
         run_next = run + 8'd1;
      end
   endfunction

   // Encoder path: change, elapsed time and the cross-multiplied rate check
   assign sel     = item.mode[0];
   assign diff    = $unsigned(item.encoder_count) - prev_count_ff[sel];
   assign mag     = diff[31] ? (32'd0 - diff) : diff;
   assign dt      = item.time_ms - prev_time_ff[sel];
   assign lhs     = 42'(mag) * 42'(MS_PER_SECOND);
   assign rhs     = 48'(cfg.rate_limit) * 48'(dt);
   assign fast    = {6'd0, lhs} > rhs;
   assign acc_sum = {1'b0, acc_ff[sel]} + {1'b0, mag};
   assign acc_sat = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
   assign trip    = acc_sat > {16'd0, cfg.distance_limit};

   // Current path
   assign mag_left   = cur_mag(item.current_left);
   assign mag_right  = cur_mag(item.current_right);
   assign over_left  = mag_left > {1'b0, cfg.current_limit};
   assign over_right = mag_right > {1'b0, cfg.current_limit};

   always_comb begin
      primed_in     = primed_ff;
      prev_count_in = prev_count_ff;
      prev_time_in  = prev_time_ff;
      acc_in        = acc_ff;
      run_in        = run_ff;
      fault         = 1'b0;
      res.fault_motor = 1'b0;
      case (item.mode)
         MODE_ENC_LEFT, MODE_ENC_RIGHT: begin
            res.fault_motor = sel;
            if (primed_ff[sel]) begin
               if (fast && trip) begin
                  fault       = 1'b1;
                  acc_in[sel] = 32'd0;
               end else if (fast) begin
                  acc_in[sel] = acc_sat;
               end else begin
                  acc_in[sel] = 32'd0;
               end
            end else begin
               primed_in[sel] = 1'b1;
            end
            prev_count_in[sel] = $unsigned(item.encoder_count);
            prev_time_in[sel]  = item.time_ms;
         end
         MODE_CURRENT: begin
            run_in[0] = run_next(run_ff[0], over_left);
            run_in[1] = run_next(run_ff[1], over_right);
         end
         default: begin
         end
      endcase
      res.runaway_trip = fault;
      res.stall_left   = run_in[0] > cfg.stall_count_limit;
      res.stall_right  = run_in[1] > cfg.stall_count_limit;
      res.estop        = fault ||
                         ((item.mode == MODE_CURRENT) && (res.stall_left || res.stall_right));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 2'b00;
         acc_ff    <= '{32'd0, 32'd0};
         run_ff    <= '{8'd0, 8'd0};
      end else if (step) begin
         primed_ff <= primed_in;
         acc_ff    <= acc_in;
         run_ff    <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         prev_count_ff <= prev_count_in;
         prev_time_ff  <= prev_time_in;
      end
   end

   a_fault_needs_primed: assert property (@(posedge clock) disable iff (reset)
      step && res.runaway_trip |-> primed_ff[sel])
      else $error("runaway fault on an unprimed motor");

   a_fault_clears_acc: assert property (@(posedge clock) disable iff (reset)
      step && res.runaway_trip |=> acc_ff[$past(sel)] == 32'd0)
      else $error("accumulator not cleared after runaway fault");

   a_idle_holds_state: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(primed_ff) && $stable(run_ff[0]) && $stable(run_ff[1]))
      else $error("motor state changed without an item");

endmodule

// ----- src/motor_stall_runaway_monitor.sv -----
// Motor stall and runaway monitor: two-motor emergency stop decision, top level.
//
// Each request beat is one sample: tuser selects a left encoder sample, a right
// encoder sample, or a current pair (code 3 changes nothing and reports the stored
// stall state). Every request beat yields exactly one response beat. A current pair
// advances each motor's run of consecutive over-limit readings (saturating at 255);
// a motor is stalled while its run exceeds stall_count_limit, and a stall seen on a
// current pair raises estop. An encoder sample compares the count change against
// the elapsed wrapping milliseconds, |change| * 1000 > rate_limit * elapsed; fast
// changes add to that motor's saturating accumulator, slow ones clear it, and an
// accumulator above distance_limit fires a runaway fault with estop and clears it.
// The first encoder sample of each motor only primes it. Throughput is one beat per
// clock while the response is not back-pressured: a request register feeds one
// evaluation stage (the 16x32 rate multiply and its compare are the longest path)
// that updates motor state and loads the response register. Write configuration
// only while idle; csr_ready is always high and unknown indexes are dropped.
module motor_stall_runaway_monitor (
   input  logic        clock,
   input  logic        reset,
   // request: tdata = encoder_count[31:0], time_ms[63:32],
   //          current_left[79:64], current_right[95:80]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,
   // request: tuser = mode[1:0]
   input  logic [1:0]  req_tuser,
   // response: tdata = estop[0], runaway_trip[1], fault_motor[2],
   //           stall_left[3], stall_right[4], zero[7:5]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   // configuration write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [msrm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                      csr_data
);
   import msrm_pkg::*;

   cfg_type  cfg;
   item_type req_item;
   item_type in_item_ff;
   logic     in_valid_ff;
   res_type  core_res;
   res_type  out_res_ff;
   logic     out_valid_ff;
   logic     advance;

   msrm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   always_comb begin
      req_item.mode          = req_tuser;
      req_item.encoder_count = $signed(req_tdata[31:0]);
      req_item.time_ms       = req_tdata[63:32];
      req_item.current_left  = $signed(req_tdata[79:64]);
      req_item.current_right = $signed(req_tdata[95:80]);
   end

   // Evaluate the held beat once the response register is free or draining.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Request register: load on accept, drop once evaluated.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_item;
      end
   end

   msrm_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_item_ff),
      .cfg   (cfg),
      .res   (core_res)
   );

   // Response register: hold until taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= core_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_res_ff.stall_right, out_res_ff.stall_left,
                        out_res_ff.fault_motor, out_res_ff.runaway_trip, out_res_ff.estop};

   a_fault_has_estop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_res_ff.runaway_trip |-> out_res_ff.estop)
      else $error("runaway fault without estop");

   a_estop_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_res_ff.estop && !out_res_ff.runaway_trip |->
         out_res_ff.stall_left || out_res_ff.stall_right)
      else $error("estop without a fault or stall");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !advance)
      else $error("response overwritten while stalled");

endmodule
